[rtl/core/sfa_pkg.sv]
// Shared types and constants of the segment fit allocator.
package sfa_pkg;

  localparam int MaxSegs  = 64;
  localparam int AddrBits = 16;
  localparam int IdxW     = $clog2(MaxSegs);
  localparam int SizeW    = AddrBits + 1;
  localparam int CntW     = $clog2(MaxSegs + 1);
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = SizeW;

  localparam logic [CfgIdxW-1:0] CfgFitIdx  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgPoolIdx = 1'b1;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CHECK = 2'd2,
    OP_INIT  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2,
    FIT_NEXT  = 2'd3
  } fit_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_MARK,
    CMD_SPLIT,
    CMD_MERGE,
    CMD_INIT
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_MERGEP,
    ST_STATS,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [AddrBits-1:0] start;
    logic [SizeW-1:0]    size;
    logic                used;
  } seg_t;

  // Table update broadcast to every cell for one cycle.
  typedef struct packed {
    cmd_e             kind;
    logic [IdxW-1:0]  idx;
    logic [SizeW-1:0] req;
    logic [SizeW-1:0] pool;
    logic             used_val;
  } cmd_t;

  // Request fields held steady during a sweep.
  typedef struct packed {
    fit_e                strat;
    logic [SizeW-1:0]    req;
    logic [AddrBits-1:0] addr;
    logic [IdxW-1:0]     rpos;
    logic [CntW-1:0]     count;
  } qry_t;

  // Record handed from cell to cell along the chain.
  typedef struct packed {
    logic                first_hit;
    logic [IdxW-1:0]     first_idx;
    logic [AddrBits-1:0] first_start;
    logic [SizeW-1:0]    first_size;
    logic                rov_hit;
    logic [IdxW-1:0]     rov_idx;
    logic [AddrBits-1:0] rov_start;
    logic [SizeW-1:0]    rov_size;
    logic                bw_hit;
    logic [IdxW-1:0]     bw_idx;
    logic [AddrBits-1:0] bw_start;
    logic [SizeW-1:0]    bw_size;
    logic [SizeW-1:0]    bw_rem;
    logic                m_hit;
    logic [IdxW-1:0]     m_idx;
    logic                m_prev_free;
    logic                m_next_free;
    logic                m_just;
    logic                prev_free;
    logic                isa;
    logic [SizeW-1:0]    abytes;
    logic [CntW-1:0]     holes;
    logic [SizeW-1:0]    big;
  } tok_t;

endpackage

[rtl/core/segment_fit_allocator_top.sv]
// Top level of the segment fit allocator: control and the chain of table cells.
// A request steps through SCAN, DECIDE, STATS and OUT to its result strobe; a
// free that merges with its free predecessor passes MERGEP too. It sweeps the
// cell chain twice (search, then statistics), one cell a cycle; a new request
// is taken only once the last is done, the next start may coincide with the
// strobe. Reset sets one free segment of 2^AddrBits bytes, first fit.
module segment_fit_allocator_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        op_i,
  input  logic [sfa_pkg::SizeW-1:0]         req_size_i,
  input  logic [sfa_pkg::AddrBits-1:0]      addr_in_i,
  input  logic                              cfg_we_i,
  input  logic [sfa_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [sfa_pkg::CfgDataW-1:0]      cfg_wdata_i,
  output logic                              valid_o,
  output logic                              ok_o,
  output logic [sfa_pkg::AddrBits-1:0]      addr_out_o,
  output logic                              is_allocated_o,
  output logic [sfa_pkg::SizeW-1:0]         allocated_bytes_o,
  output logic [sfa_pkg::CntW-1:0]          hole_count_o,
  output logic [sfa_pkg::SizeW-1:0]         largest_free_o
);

  localparam int N = sfa_pkg::MaxSegs;
  localparam logic [sfa_pkg::SizeW-1:0] PoolCap =
    sfa_pkg::SizeW'(1) << sfa_pkg::AddrBits;

  sfa_pkg::state_e state_q, state_d;
  logic [sfa_pkg::IdxW-1:0]     cnt_q, cnt_d;
  sfa_pkg::op_e                 op_q;
  logic [sfa_pkg::SizeW-1:0]    req_q;
  logic [sfa_pkg::AddrBits-1:0] addr_q;
  sfa_pkg::fit_e                fit_q;
  logic [sfa_pkg::SizeW-1:0]    pool_q;
  logic [sfa_pkg::CntW-1:0]     count_q, count_d;
  logic [sfa_pkg::IdxW-1:0]     rover_q, rover_d;
  logic [sfa_pkg::IdxW-1:0]     j_q, j_d;
  logic                         ok_q, ok_d;
  logic [sfa_pkg::AddrBits-1:0] aout_q, aout_d;
  logic                         isa_q, isa_d;
  logic                         valid_q;
  logic [sfa_pkg::SizeW-1:0]    abytes_q, big_q;
  logic [sfa_pkg::CntW-1:0]     holes_q;
  logic                         accept;

  sfa_pkg::qry_t qry;
  sfa_pkg::cmd_t cmd;
  sfa_pkg::seg_t segs [N];
  sfa_pkg::tok_t toks [N];
  sfa_pkg::tok_t last;

  assign accept = start && (state_q == sfa_pkg::ST_IDLE);
  assign busy   = (state_q != sfa_pkg::ST_IDLE);
  assign last   = toks[N-1];

  always_comb begin
    qry.strat = fit_q;
    qry.req   = req_q;
    qry.addr  = addr_q;
    qry.rpos  = (sfa_pkg::CntW'(rover_q) < count_q) ? rover_q : '0;
    qry.count = count_q;
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    sfa_pkg::seg_t left, right;
    sfa_pkg::tok_t tin;
    if (g == 0) begin : g_head
      assign left = '0;
      assign tin  = '0;
    end else begin : g_body
      assign left = segs[g-1];
      assign tin  = toks[g-1];
    end
    if (g == N - 1) begin : g_tail
      assign right = '0;
    end else begin : g_inner
      assign right = segs[g+1];
    end
    sfa_cell #(.CellIdx(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .qry_i   (qry),
      .cmd_i   (cmd),
      .left_i  (left),
      .right_i (right),
      .tok_i   (tin),
      .tok_o   (toks[g]),
      .seg_o   (segs[g])
    );
  end

  // rover after entry k is removed and the table holds cnt entries
  function automatic logic [sfa_pkg::IdxW-1:0] rover_after(
    input logic [sfa_pkg::IdxW-1:0] rov,
    input logic [sfa_pkg::IdxW-1:0] k,
    input logic [sfa_pkg::CntW-1:0] cnt
  );
    logic [sfa_pkg::IdxW-1:0] r;
    r = rov;
    if (rov == k) r = k - 1'b1;
    else if (rov > k) r = rov - 1'b1;
    if (sfa_pkg::CntW'(r) >= cnt) r = '0;
    return r;
  endfunction

  always_comb begin
    logic                         hit;
    logic [sfa_pkg::IdxW-1:0]     p_idx;
    logic [sfa_pkg::AddrBits-1:0] p_start;
    logic [sfa_pkg::SizeW-1:0]    p_size;
    logic [sfa_pkg::SizeW-1:0]    pool_sat;
    state_d  = state_q;
    cnt_d    = cnt_q;
    count_d  = count_q;
    rover_d  = rover_q;
    j_d      = j_q;
    ok_d     = ok_q;
    aout_d   = aout_q;
    isa_d    = isa_q;
    cmd      = '0;
    cmd.kind = sfa_pkg::CMD_NONE;
    cmd.req  = req_q;

    pool_sat = pool_q;
    if (pool_q == '0) pool_sat = sfa_pkg::SizeW'(1);
    else if (pool_q > PoolCap) pool_sat = PoolCap;
    cmd.pool = pool_sat;

    case (fit_q)
      sfa_pkg::FIT_FIRST: begin
        hit = last.first_hit; p_idx = last.first_idx;
        p_start = last.first_start; p_size = last.first_size;
      end
      sfa_pkg::FIT_NEXT: begin
        if (last.rov_hit) begin
          hit = 1'b1; p_idx = last.rov_idx;
          p_start = last.rov_start; p_size = last.rov_size;
        end else begin
          hit = last.first_hit; p_idx = last.first_idx;
          p_start = last.first_start; p_size = last.first_size;
        end
      end
      default: begin
        hit = last.bw_hit; p_idx = last.bw_idx;
        p_start = last.bw_start; p_size = last.bw_size;
      end
    endcase

    case (state_q)
      sfa_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = sfa_pkg::ST_SCAN;
          cnt_d   = '0;
          ok_d    = 1'b0;
          aout_d  = '0;
          isa_d   = 1'b0;
        end
      end
      sfa_pkg::ST_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == sfa_pkg::IdxW'(N - 1)) state_d = sfa_pkg::ST_DECIDE;
      end
      sfa_pkg::ST_DECIDE: begin
        state_d = sfa_pkg::ST_STATS;
        cnt_d   = '0;
        case (op_q)
          sfa_pkg::OP_ALLOC: begin
            if (req_q != '0 && hit) begin
              if (p_size == req_q) begin
                cmd.kind     = sfa_pkg::CMD_MARK;
                cmd.idx      = p_idx;
                cmd.used_val = 1'b1;
                rover_d = (sfa_pkg::CntW'(p_idx) + 1'b1 < count_q) ? p_idx + 1'b1 : '0;
                ok_d    = 1'b1;
                aout_d  = p_start;
              end else if (count_q != sfa_pkg::CntW'(N)) begin
                cmd.kind = sfa_pkg::CMD_SPLIT;
                cmd.idx  = p_idx;
                count_d  = count_q + 1'b1;
                rover_d  = p_idx + 1'b1;
                ok_d     = 1'b1;
                aout_d   = p_start;
              end
            end
          end
          sfa_pkg::OP_FREE: begin
            if (last.m_hit) begin
              ok_d = 1'b1;
              j_d  = last.m_idx;
              if (last.m_next_free) begin
                cmd.kind = sfa_pkg::CMD_MERGE;
                cmd.idx  = last.m_idx + 1'b1;
                count_d  = count_q - 1'b1;
                rover_d  = rover_after(rover_q, last.m_idx + 1'b1, count_q - 1'b1);
              end else begin
                cmd.kind     = sfa_pkg::CMD_MARK;
                cmd.idx      = last.m_idx;
                cmd.used_val = 1'b0;
              end
              if (last.m_idx != '0 && last.m_prev_free) state_d = sfa_pkg::ST_MERGEP;
            end
          end
          sfa_pkg::OP_CHECK: begin
            ok_d  = 1'b1;
            isa_d = last.isa;
          end
          default: begin
            cmd.kind = sfa_pkg::CMD_INIT;
            count_d  = sfa_pkg::CntW'(1);
            rover_d  = '0;
            ok_d     = 1'b1;
          end
        endcase
      end
      sfa_pkg::ST_MERGEP: begin
        // fold the freed entry into its free predecessor
        cmd.kind = sfa_pkg::CMD_MERGE;
        cmd.idx  = j_q;
        count_d  = count_q - 1'b1;
        rover_d  = rover_after(rover_q, j_q, count_q - 1'b1);
        state_d  = sfa_pkg::ST_STATS;
        cnt_d    = '0;
      end
      sfa_pkg::ST_STATS: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == sfa_pkg::IdxW'(N - 1)) state_d = sfa_pkg::ST_OUT;
      end
      sfa_pkg::ST_OUT: state_d = sfa_pkg::ST_IDLE;
      default: state_d = sfa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sfa_pkg::ST_IDLE;
      cnt_q   <= '0;
      count_q <= sfa_pkg::CntW'(1);
      rover_q <= '0;
      fit_q   <= sfa_pkg::FIT_FIRST;
      pool_q  <= PoolCap;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      count_q <= count_d;
      rover_q <= rover_d;
      valid_q <= (state_q == sfa_pkg::ST_OUT);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sfa_pkg::CfgFitIdx:  fit_q  <= sfa_pkg::fit_e'(cfg_wdata_i[1:0]);
          sfa_pkg::CfgPoolIdx: pool_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= sfa_pkg::op_e'(op_i);
      req_q  <= req_size_i;
      addr_q <= addr_in_i;
    end
    j_q    <= j_d;
    ok_q   <= ok_d;
    aout_q <= aout_d;
    isa_q  <= isa_d;
    if (state_q == sfa_pkg::ST_OUT) begin
      abytes_q <= last.abytes;
      holes_q  <= last.holes;
      big_q    <= last.big;
    end
  end

  assign valid_o           = valid_q;
  assign ok_o              = ok_q;
  assign addr_out_o        = aout_q;
  assign is_allocated_o    = isa_q;
  assign allocated_bytes_o = abytes_q;
  assign hole_count_o      = holes_q;
  assign largest_free_o    = big_q;

endmodule

[rtl/core/sfa_cell.sv]
// One table entry of the segment chain with its sweep stage.
module sfa_cell #(
  parameter int CellIdx = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sfa_pkg::qry_t qry_i,
  input  sfa_pkg::cmd_t cmd_i,
  input  sfa_pkg::seg_t left_i,
  input  sfa_pkg::seg_t right_i,
  input  sfa_pkg::tok_t tok_i,
  output sfa_pkg::tok_t tok_o,
  output sfa_pkg::seg_t seg_o
);

  localparam logic [sfa_pkg::SizeW-1:0] PoolCap =
    sfa_pkg::SizeW'(1) << sfa_pkg::AddrBits;

  sfa_pkg::seg_t seg_q, seg_d;
  sfa_pkg::tok_t tok_q, tok_d;

  always_comb begin
    int k;
    k = int'(cmd_i.idx);
    seg_d = seg_q;
    case (cmd_i.kind)
      sfa_pkg::CMD_INIT: begin
        if (CellIdx == 0) begin
          seg_d.start = '0;
          seg_d.size  = cmd_i.pool;
          seg_d.used  = 1'b0;
        end
      end
      sfa_pkg::CMD_MARK: begin
        if (CellIdx == k) seg_d.used = cmd_i.used_val;
      end
      sfa_pkg::CMD_SPLIT: begin
        if (CellIdx == k) begin
          seg_d.size = cmd_i.req;
          seg_d.used = 1'b1;
        end else if (CellIdx == k + 1) begin
          seg_d.start = left_i.start + cmd_i.req[sfa_pkg::AddrBits-1:0];
          seg_d.size  = left_i.size - cmd_i.req;
          seg_d.used  = 1'b0;
        end else if (CellIdx > k + 1) begin
          seg_d = left_i;
        end
      end
      sfa_pkg::CMD_MERGE: begin
        // absorb the right neighbor, shift the tail down by one
        if (CellIdx == k - 1) begin
          seg_d.size = seg_q.size + right_i.size;
          seg_d.used = 1'b0;
        end else if (CellIdx >= k) begin
          seg_d = right_i;
        end
      end
      default: seg_d = seg_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q.start <= '0;
      seg_q.size  <= (CellIdx == 0) ? PoolCap : '0;
      seg_q.used  <= 1'b0;
    end else begin
      seg_q <= seg_d;
    end
  end

  always_comb begin
    logic                   valid;
    logic                   fit;
    logic                   is_free;
    logic [sfa_pkg::SizeW-1:0] rem;
    logic [sfa_pkg::SizeW:0]   seg_end;
    valid   = CellIdx < int'(qry_i.count);
    is_free = valid && !seg_q.used;
    fit     = is_free && (seg_q.size >= qry_i.req);
    rem     = seg_q.size - qry_i.req;
    seg_end = {2'b00, seg_q.start} + {1'b0, seg_q.size};
    tok_d   = tok_i;

    if (fit && !tok_i.first_hit) begin
      tok_d.first_hit   = 1'b1;
      tok_d.first_idx   = sfa_pkg::IdxW'(CellIdx);
      tok_d.first_start = seg_q.start;
      tok_d.first_size  = seg_q.size;
    end
    if (fit && !tok_i.rov_hit && CellIdx >= int'(qry_i.rpos)) begin
      tok_d.rov_hit   = 1'b1;
      tok_d.rov_idx   = sfa_pkg::IdxW'(CellIdx);
      tok_d.rov_start = seg_q.start;
      tok_d.rov_size  = seg_q.size;
    end
    if (fit && (!tok_i.bw_hit ||
                (qry_i.strat == sfa_pkg::FIT_BEST && rem < tok_i.bw_rem) ||
                (qry_i.strat == sfa_pkg::FIT_WORST && rem > tok_i.bw_rem))) begin
      tok_d.bw_hit   = 1'b1;
      tok_d.bw_idx   = sfa_pkg::IdxW'(CellIdx);
      tok_d.bw_start = seg_q.start;
      tok_d.bw_size  = seg_q.size;
      tok_d.bw_rem   = rem;
    end

    // record whether the entry after the matching one is free
    if (tok_i.m_just) begin
      tok_d.m_next_free = is_free;
      tok_d.m_just      = 1'b0;
    end
    if (valid && !tok_i.m_hit && seg_q.start == qry_i.addr) begin
      tok_d.m_hit       = 1'b1;
      tok_d.m_idx       = sfa_pkg::IdxW'(CellIdx);
      tok_d.m_prev_free = tok_i.prev_free;
      tok_d.m_just      = 1'b1;
    end

    if (valid && seg_q.used && {2'b00, qry_i.addr} < seg_end &&
        qry_i.addr >= seg_q.start) begin
      tok_d.isa = 1'b1;
    end

    if (valid && seg_q.used) tok_d.abytes = tok_i.abytes + seg_q.size;
    if (is_free) begin
      // count the first entry of each free run
      if (!tok_i.prev_free) tok_d.holes = tok_i.holes + sfa_pkg::CntW'(1);
      if (seg_q.size > tok_i.big) tok_d.big = seg_q.size;
    end
    tok_d.prev_free = is_free;
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign tok_o = tok_q;
  assign seg_o = seg_q;

endmodule

[rtl/core/sfa_checker.sv]
// Port-level checks of the segment fit allocator and their bind.
module sfa_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         valid_o,
  input logic                         ok_o,
  input logic                         is_allocated_o,
  input logic [sfa_pkg::CntW-1:0]     hole_count_o
);

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy) else $error("result strobe while busy");

  a_done_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> valid_o) else $error("request finished without result");

  a_take_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !valid_o)) else $error("request not taken");

  a_check_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && is_allocated_o) |-> ok_o) else $error("hit reported with failure");

  a_hole_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (hole_count_o <= sfa_pkg::CntW'(sfa_pkg::MaxSegs)))
    else $error("hole count above table depth");

endmodule

bind segment_fit_allocator_top sfa_checker u_sfa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .valid_o        (valid_o),
  .ok_o           (ok_o),
  .is_allocated_o (is_allocated_o),
  .hole_count_o   (hole_count_o)
);
